@@ design/self_adaptive_de_trial_engine_unit_defines.svh @@
// Assertion macros used by the checker file of the trial engine.
`ifndef SELF_ADAPTIVE_DE_TRIAL_ENGINE_UNIT_DEFINES_SVH
`define SELF_ADAPTIVE_DE_TRIAL_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication
`define SADTE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SADTE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication after a fixed number of cycles
`define SADTE_ASSERT_DLY(label, clk, rst_n, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ## dly (cons)) \
        else $error(msg);

`endif

@@ design/sadte_pkg.sv @@
// Types and constants of the self-adaptive DE trial engine.
package sadte_pkg;

    localparam int POP_SIZE_DEF  = 64;
    localparam int GENE_BITS_DEF = 32;

    localparam int F_W        = 17;
    localparam int CR_W       = 16;
    localparam int RAND_W     = 16;
    localparam int FRAC_W     = 16;
    localparam int X_W        = 32;
    localparam int REQ_W      = 2;
    localparam int IND_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [F_W-1:0]         F_RESET       = 17'd32768;
    localparam logic [CR_W-1:0]        CR_RESET      = 16'd58982;
    localparam logic [F_W-1:0]         F_LOWER_RESET = 17'd6554;
    localparam logic [F_W-1:0]         F_UPPER_RESET = 17'd58982;
    localparam logic [RAND_W-1:0]      TAU_RESET     = 16'd6554;
    localparam logic signed [X_W-1:0]  X_MIN_RESET   = -32'sd6553600;
    localparam logic signed [X_W-1:0]  X_MAX_RESET   = 32'sd6553600;

    localparam logic [CFG_IDX_W-1:0] CFG_F_LOWER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_F_UPPER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAU     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MAX   = 3'd4;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADAPT  = 2'd0,
        REQ_TRIAL  = 2'd1,
        REQ_SELECT = 2'd2,
        REQ_NOP    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [F_W-1:0]  f;
        logic [CR_W-1:0] cr;
    } t_fcr;

    typedef struct packed {
        logic we_adp;
        logic we_cnd;
        t_fcr adp;
        t_fcr cnd;
    } t_mem_wr;

endpackage

@@ design/self_adaptive_de_trial_engine_unit.sv @@
// Top level of the self-adaptive DE trial engine: control, shared multiplier, bounds.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------------
//  request   | start / busy           | i_req_type .. i_spare_zero
//  result    | o_valid (strobe)       | o_trial_f, o_trial_cr, o_trial_gene, o_accepted
//  config    | i_cfg_we               | i_cfg_addr, i_cfg_wdata
//
// An item goes through a table read, one pass through the shared 18 x (GENE_BITS+1)
// multiplier, then bounds check and table write-back. Its result strobes for one cycle
// right after, and the next beat can be accepted in that same cycle.
// After reset a clearing pass writes every entry of both tables with busy high.
// Results cannot be held off by the receiver.
module self_adaptive_de_trial_engine_unit #(
    parameter int POP_SIZE  = sadte_pkg::POP_SIZE_DEF,
    parameter int GENE_BITS = sadte_pkg::GENE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sadte_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [sadte_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                                start,
    output logic                                busy,
    input  logic [sadte_pkg::REQ_W-1:0]         i_req_type,
    input  logic [sadte_pkg::IND_W-1:0]         i_individual,
    input  logic [sadte_pkg::RAND_W-1:0]        i_rand_a,
    input  logic [sadte_pkg::RAND_W-1:0]        i_rand_b,
    input  logic [sadte_pkg::RAND_W-1:0]        i_rand_c,
    input  logic [sadte_pkg::RAND_W-1:0]        i_rand_d,
    input  logic signed [GENE_BITS-1:0]         i_target_gene,
    input  logic signed [GENE_BITS-1:0]         i_base_gene,
    input  logic signed [GENE_BITS-1:0]         i_diff_plus,
    input  logic signed [GENE_BITS-1:0]         i_diff_minus,
    input  logic                                i_forced_dim,
    input  logic                                i_spare_zero,
    output logic                                o_valid,
    output logic [sadte_pkg::F_W-1:0]           o_trial_f,
    output logic [sadte_pkg::CR_W-1:0]          o_trial_cr,
    output logic signed [GENE_BITS-1:0]         o_trial_gene,
    output logic                                o_accepted
);
    import sadte_pkg::*;

    localparam int AW = (POP_SIZE > 1) ? $clog2(POP_SIZE) : 1;
    localparam int IND_N = 1 << IND_W;
    localparam int DW = GENE_BITS + 1;          // donor difference
    localparam int PW = DW + F_W + 1;           // product
    localparam int TW = PW - FRAC_W;            // product scaled back
    localparam int MW = (GENE_BITS + 4 > X_W + 1) ? GENE_BITS + 4 : X_W + 1;

    // configuration
    logic [F_W-1:0]        r_f_lower;
    logic [F_W-1:0]        r_f_upper;
    logic [RAND_W-1:0]     r_tau;
    logic signed [X_W-1:0] r_x_min;
    logic signed [X_W-1:0] r_x_max;

    // control
    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_clr;
    logic          r_valid;

    // captured beat
    t_req                      r_req;
    logic [AW-1:0]             r_idx;
    logic [RAND_W-1:0]         r_ra;
    logic [RAND_W-1:0]         r_rb;
    logic [RAND_W-1:0]         r_rc;
    logic [RAND_W-1:0]         r_rd;
    logic signed [GENE_BITS-1:0] r_target;
    logic signed [GENE_BITS-1:0] r_base;
    logic signed [GENE_BITS-1:0] r_plus;
    logic signed [GENE_BITS-1:0] r_minus;
    logic                      r_forced;

    // multiply stage results
    logic signed [PW-1:0]        r_prod;
    logic                        r_use_mut;
    logic signed [GENE_BITS-1:0] r_mid_lo;
    logic signed [GENE_BITS-1:0] r_mid_hi;

    // result registers
    logic [F_W-1:0]              r_out_f;
    logic [CR_W-1:0]             r_out_cr;
    logic signed [GENE_BITS-1:0] r_out_gene;
    logic                        r_out_acc;

    logic          accept;
    logic [AW-1:0] idx_in;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    t_mem_wr       mem_wr;
    t_fcr          adp_q;
    t_fcr          cnd_q;
    t_fcr          adapt_fcr;
    t_fcr          fcr_rst;

    logic [F_W-1:0]              mul_a;
    logic signed [DW-1:0]        mul_b;
    logic signed [DW-1:0]        diff;
    logic signed [PW-1:0]        prod;
    logic signed [MW-1:0]        mid_lo_sum;
    logic signed [MW-1:0]        mid_hi_sum;
    logic signed [TW-1:0]        term;
    logic [F_W:0]                f_sum;
    logic [F_W-1:0]              f_new;
    logic signed [MW-1:0]        mut;
    logic                        below;
    logic                        above;
    logic signed [GENE_BITS-1:0] gene_mut;
    logic signed [GENE_BITS-1:0] gene_out;
    logic                        sel_ok;

    assign accept = start && !busy;
    assign fcr_rst = '{f: F_RESET, cr: CR_RESET};

    // individual modulo table size, as a constant lookup over the 6-bit index
    always_comb begin
        idx_in = '0;
        for (int k = 0; k < IND_N; k++) begin
            if (i_individual == IND_W'(k)) begin
                idx_in = AW'(k % POP_SIZE);
            end
        end
    end

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_lower <= F_LOWER_RESET;
            r_f_upper <= F_UPPER_RESET;
            r_tau     <= TAU_RESET;
            r_x_min   <= X_MIN_RESET;
            r_x_max   <= X_MAX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_F_LOWER: r_f_lower <= i_cfg_wdata[F_W-1:0];
                CFG_F_UPPER: r_f_upper <= i_cfg_wdata[F_W-1:0];
                CFG_TAU:     r_tau     <= i_cfg_wdata[RAND_W-1:0];
                CFG_X_MIN:   r_x_min   <= i_cfg_wdata[X_W-1:0];
                CFG_X_MAX:   r_x_max   <= i_cfg_wdata[X_W-1:0];
                default: ;
            endcase
        end
    end

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_FIN);
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr == AW'(POP_SIZE - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (start) n_state = ST_MUL;
            ST_MUL:   n_state = ST_FIN;
            ST_FIN:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy          = (r_state != ST_IDLE);
        raddr         = (r_state == ST_IDLE) ? idx_in : r_idx;
        waddr         = (r_state == ST_CLEAR) ? r_clr : r_idx;
        mem_wr.we_cnd = (r_state == ST_CLEAR) || ((r_state == ST_FIN) && (r_req == REQ_ADAPT));
        mem_wr.we_adp = (r_state == ST_CLEAR) ||
                        ((r_state == ST_FIN) && (r_req == REQ_SELECT) && sel_ok);
        mem_wr.cnd    = (r_state == ST_CLEAR) ? fcr_rst : adapt_fcr;
        mem_wr.adp    = (r_state == ST_CLEAR) ? fcr_rst : cnd_q;
    end

    sadte_param_mem #(
        .POP_SIZE (POP_SIZE)
    ) u_mem (
        .i_clk   (i_clk),
        .i_wr    (mem_wr),
        .i_waddr (waddr),
        .i_raddr (raddr),
        .o_adp   (adp_q),
        .o_cnd   (cnd_q)
    );

    // capture beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req    <= t_req'(i_req_type);
            r_idx    <= idx_in;
            r_ra     <= i_rand_a;
            r_rb     <= i_rand_b;
            r_rc     <= i_rand_c;
            r_rd     <= i_rand_d;
            r_target <= i_target_gene;
            r_base   <= i_base_gene;
            r_plus   <= i_diff_plus;
            r_minus  <= i_diff_minus;
            r_forced <= i_forced_dim;
        end
    end

    // multiply stage: adapt scales rand_a by f_upper, trial scales the difference by F
    always_comb begin
        diff       = DW'(r_plus) - DW'(r_minus);
        mul_a      = (r_req == REQ_ADAPT) ? r_f_upper : cnd_q.f;
        mul_b      = (r_req == REQ_ADAPT) ? $signed({{(DW - RAND_W){1'b0}}, r_ra}) : diff;
        prod       = PW'($signed({1'b0, mul_a})) * PW'(mul_b);
        mid_lo_sum = MW'(r_x_min) + MW'(r_target);
        mid_hi_sum = MW'(r_x_max) + MW'(r_target);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            r_prod    <= prod;
            r_use_mut <= (r_ra < cnd_q.cr) || r_forced;
            r_mid_lo  <= mid_lo_sum[GENE_BITS:1];
            r_mid_hi  <= mid_hi_sum[GENE_BITS:1];
        end
    end

    // finish stage
    always_comb begin
        term        = r_prod[PW-1:FRAC_W];
        f_sum       = {1'b0, r_f_lower} + {1'b0, term[F_W-1:0]};
        f_new       = f_sum[F_W] ? {F_W{1'b1}} : f_sum[F_W-1:0];
        adapt_fcr.f  = (r_rb < r_tau) ? f_new : adp_q.f;
        adapt_fcr.cr = (r_rd < r_tau) ? r_rc : adp_q.cr;
        mut         = MW'(r_base) + MW'(term);
        below       = mut < MW'(r_x_min);
        above       = mut > MW'(r_x_max);
        // lower bound is tested first when the bounds are crossed
        if (below) begin
            gene_mut = r_mid_lo;
        end else if (above) begin
            gene_mut = r_mid_hi;
        end else begin
            gene_mut = mut[GENE_BITS-1:0];
        end
        gene_out    = r_use_mut ? gene_mut : r_target;
        sel_ok      = (r_base <= r_target);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN) begin
            r_out_f    <= (r_req == REQ_ADAPT) ? adapt_fcr.f : cnd_q.f;
            r_out_cr   <= (r_req == REQ_ADAPT) ? adapt_fcr.cr : cnd_q.cr;
            r_out_gene <= (r_req == REQ_TRIAL) ? gene_out : '0;
            r_out_acc  <= (r_req == REQ_SELECT) && sel_ok;
        end
    end

    assign o_valid      = r_valid;
    assign o_trial_f    = r_out_f;
    assign o_trial_cr   = r_out_cr;
    assign o_trial_gene = r_out_gene;
    assign o_accepted   = r_out_acc;

endmodule

@@ design/sadte_param_mem.sv @@
// Adopted and candidate F/CR tables, one write and one registered read port each.
module sadte_param_mem #(
    parameter int POP_SIZE = sadte_pkg::POP_SIZE_DEF
) (
    input  logic                                     i_clk,
    input  sadte_pkg::t_mem_wr                       i_wr,
    input  logic [((POP_SIZE > 1) ? $clog2(POP_SIZE) : 1)-1:0] i_waddr,
    input  logic [((POP_SIZE > 1) ? $clog2(POP_SIZE) : 1)-1:0] i_raddr,
    output sadte_pkg::t_fcr                          o_adp,
    output sadte_pkg::t_fcr                          o_cnd
);
    import sadte_pkg::*;

    t_fcr r_adp_mem [POP_SIZE];
    t_fcr r_cnd_mem [POP_SIZE];
    t_fcr r_adp_q;
    t_fcr r_cnd_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.we_adp) begin
            r_adp_mem[i_waddr] <= i_wr.adp;
        end
        r_adp_q <= r_adp_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we_cnd) begin
            r_cnd_mem[i_waddr] <= i_wr.cnd;
        end
        r_cnd_q <= r_cnd_mem[i_raddr];
    end

    assign o_adp = r_adp_q;
    assign o_cnd = r_cnd_q;

endmodule

@@ design/sadte_checker.sv @@
// Port-level checks of the trial engine and their binding to the top level.
`include "self_adaptive_de_trial_engine_unit_defines.svh"

module sadte_checker #(
    parameter int GENE_BITS = sadte_pkg::GENE_BITS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [sadte_pkg::REQ_W-1:0] i_req_type,
    input logic                        o_valid,
    input logic [GENE_BITS-1:0]        o_trial_gene,
    input logic                        o_accepted
);
    import sadte_pkg::*;

    `SADTE_ASSERT_NXT(a_busy_after_beat, i_clk, i_rst_n, start && !busy, busy, "beat taken but busy low")
    `SADTE_ASSERT_DLY(a_result_latency, i_clk, i_rst_n, start && !busy, 3, o_valid, "result strobe missing")
    `SADTE_ASSERT_IMP(a_idle_on_result, i_clk, i_rst_n, o_valid, !busy, "busy while result shown")
    `SADTE_ASSERT_DLY(a_acc_only_select, i_clk, i_rst_n, start && !busy && (i_req_type != REQ_SELECT), 3, !o_accepted, "accepted set outside select")
    `SADTE_ASSERT_DLY(a_gene_only_trial, i_clk, i_rst_n, start && !busy && (i_req_type != REQ_TRIAL), 3, o_trial_gene == '0, "gene nonzero outside trial")

endmodule

bind self_adaptive_de_trial_engine_unit sadte_checker #(
    .GENE_BITS (GENE_BITS)
) u_sadte_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_req_type   (i_req_type),
    .o_valid      (o_valid),
    .o_trial_gene (o_trial_gene),
    .o_accepted   (o_accepted)
);

@@ sim/self_adaptive_de_trial_engine_unit_tb.sv @@
// Self-checking testbench of the self-adaptive DE trial engine: directed table, random generations.
module self_adaptive_de_trial_engine_unit_tb;
    import sadte_pkg::*;

    localparam int                WATCHDOG_LIMIT = 2000;
    localparam int                PHASES         = 6;
    localparam int                PHASE_ITEMS    = 290;
    localparam int                DIR_ROWS       = 20;
    localparam int                MAX_PRINTS     = 60;
    localparam logic [X_W-1:0]    G_MAX          = 32'h7fffffff;
    localparam logic [X_W-1:0]    G_MIN          = 32'h80000000;
    localparam logic [X_W-1:0]    G_ONES         = 32'hffffffff;
    localparam logic [RAND_W-1:0] R_MAX          = 16'hffff;
    localparam logic [F_W-1:0]    F_SAT          = 17'h1ffff;

    typedef struct packed {
        t_req              req;
        logic [IND_W-1:0]  ind;
        logic [RAND_W-1:0] ra;
        logic [RAND_W-1:0] rb;
        logic [RAND_W-1:0] rc;
        logic [RAND_W-1:0] rd;
        logic [X_W-1:0]    target;
        logic [X_W-1:0]    base;
        logic [X_W-1:0]    plus;
        logic [X_W-1:0]    minus;
        logic              forced;
        logic              spare;
    } request_t;

    typedef struct packed {
        logic [F_W-1:0]  f;
        logic [CR_W-1:0] cr;
        logic [X_W-1:0]  gene;
        logic            acc;
    } outcome_t;

    typedef struct packed {
        request_t rq;
        logic     typed;
        outcome_t want;
    } dir_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  start;
    logic                  busy;
    logic [REQ_W-1:0]      i_req_type;
    logic [IND_W-1:0]      i_individual;
    logic [RAND_W-1:0]     i_rand_a;
    logic [RAND_W-1:0]     i_rand_b;
    logic [RAND_W-1:0]     i_rand_c;
    logic [RAND_W-1:0]     i_rand_d;
    logic signed [X_W-1:0] i_target_gene;
    logic signed [X_W-1:0] i_base_gene;
    logic signed [X_W-1:0] i_diff_plus;
    logic signed [X_W-1:0] i_diff_minus;
    logic                  i_forced_dim;
    logic                  i_spare_zero;
    logic                  o_valid;
    logic [F_W-1:0]        o_trial_f;
    logic [CR_W-1:0]       o_trial_cr;
    logic signed [X_W-1:0] o_trial_gene;
    logic                  o_accepted;

    self_adaptive_de_trial_engine_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_individual (i_individual),
        .i_rand_a     (i_rand_a),
        .i_rand_b     (i_rand_b),
        .i_rand_c     (i_rand_c),
        .i_rand_d     (i_rand_d),
        .i_target_gene(i_target_gene),
        .i_base_gene  (i_base_gene),
        .i_diff_plus  (i_diff_plus),
        .i_diff_minus (i_diff_minus),
        .i_forced_dim (i_forced_dim),
        .i_spare_zero (i_spare_zero),
        .o_valid      (o_valid),
        .o_trial_f    (o_trial_f),
        .o_trial_cr   (o_trial_cr),
        .o_trial_gene (o_trial_gene),
        .o_accepted   (o_accepted)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the engine: parameter tables and registers
    logic [F_W-1:0]  adp_f  [POP_SIZE_DEF];
    logic [CR_W-1:0] adp_cr [POP_SIZE_DEF];
    logic [F_W-1:0]  cnd_f  [POP_SIZE_DEF];
    logic [CR_W-1:0] cnd_cr [POP_SIZE_DEF];
    logic [F_W-1:0]  f_lo_r;
    logic [F_W-1:0]  f_span_r;
    logic [RAND_W-1:0] tau_r;
    longint          xmin_r;
    longint          xmax_r;

    outcome_t        pending_results[$];
    int              err_count   = 0;
    int              stall_cycles = 0;
    logic            cur_typed   = 1'b0;
    outcome_t        cur_want    = '0;
    int              gap_pct     = 0;
    int              burst_left  = 0;
    logic [RAND_W-1:0] draw_tau  = TAU_RESET;

    // directed beats; typed rows carry an expectation that follows from the defaults and the earlier rows
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{'{REQ_NOP, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0},
          1'b1, '{17'd32768, 16'd58982, 32'd0, 1'b0}},
        '{'{REQ_ADAPT, 6'd1, 16'd0, R_MAX, 16'd0, R_MAX, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0},
          1'b1, '{17'd32768, 16'd58982, 32'd0, 1'b0}},
        '{'{REQ_ADAPT, 6'd2, R_MAX, 16'd6554, R_MAX, 16'd6554, 32'd0, 32'd0, 32'd0, 32'd0,
            1'b0, 1'b0}, 1'b1, '{17'd32768, 16'd58982, 32'd0, 1'b0}},
        '{'{REQ_ADAPT, 6'd3, R_MAX, 16'd6553, 16'h1234, 16'd6553, 32'd0, 32'd0, 32'd0, 32'd0,
            1'b0, 1'b0}, 1'b0, '0},
        '{'{REQ_ADAPT, 6'd4, 16'd0, 16'd0, R_MAX, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0},
          1'b1, '{17'd6554, 16'd65535, 32'd0, 1'b0}},
        '{'{REQ_TRIAL, 6'd1, R_MAX, 16'd0, 16'd0, 16'd0, G_MAX, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0},
          1'b1, '{17'd32768, 16'd58982, G_MAX, 1'b0}},
        '{'{REQ_TRIAL, 6'd1, 16'd58982, 16'd0, 16'd0, 16'd0, G_MIN, G_MAX, G_MAX, G_MIN,
            1'b0, 1'b0}, 1'b1, '{17'd32768, 16'd58982, G_MIN, 1'b0}},
        '{'{REQ_TRIAL, 6'd1, R_MAX, 16'd0, 16'd0, 16'd0, 32'd0, 32'h10000, 32'h20000, 32'd0,
            1'b1, 1'b0}, 1'b0, '0},
        '{'{REQ_TRIAL, 6'd4, 16'd0, 16'd0, 16'd0, 16'd0, 32'h10000, 32'd0, G_MAX, G_MIN,
            1'b0, 1'b0}, 1'b0, '0},
        '{'{REQ_TRIAL, 6'd4, R_MAX, 16'd0, 16'd0, 16'd0, G_MIN, G_MIN, G_MIN, G_MAX, 1'b1, 1'b0},
          1'b0, '0},
        '{'{REQ_TRIAL, 6'd3, R_MAX, 16'd0, 16'd0, 16'd0, G_MAX, G_MAX, 32'd0, 32'd0, 1'b1, 1'b0},
          1'b0, '0},
        '{'{REQ_SELECT, 6'd2, 16'd0, 16'd0, 16'd0, 16'd0, 32'd5, 32'd5, 32'd0, 32'd0, 1'b0, 1'b0},
          1'b1, '{17'd32768, 16'd58982, 32'd0, 1'b1}},
        '{'{REQ_SELECT, 6'd2, 16'd0, 16'd0, 16'd0, 16'd0, G_ONES, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0},
          1'b1, '{17'd32768, 16'd58982, 32'd0, 1'b0}},
        '{'{REQ_SELECT, 6'd4, 16'd0, 16'd0, 16'd0, 16'd0, G_MAX, G_MIN, 32'd0, 32'd0, 1'b0, 1'b0},
          1'b1, '{17'd6554, 16'd65535, 32'd0, 1'b1}},
        '{'{REQ_ADAPT, 6'd4, 16'd0, R_MAX, 16'd0, R_MAX, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0},
          1'b1, '{17'd6554, 16'd65535, 32'd0, 1'b0}},
        '{'{REQ_SELECT, 6'd3, 16'd0, 16'd0, 16'd0, 16'd0, G_MIN, G_MAX, 32'd0, 32'd0, 1'b0, 1'b0},
          1'b0, '0},
        '{'{REQ_TRIAL, 6'd63, R_MAX, R_MAX, R_MAX, R_MAX, G_ONES, G_ONES, G_ONES, G_ONES,
            1'b1, 1'b1}, 1'b0, '0},
        '{'{REQ_NOP, 6'd63, R_MAX, R_MAX, R_MAX, R_MAX, G_MAX, G_MAX, G_MAX, G_MAX, 1'b1, 1'b1},
          1'b1, '{17'd32768, 16'd58982, 32'd0, 1'b0}},
        '{'{REQ_ADAPT, 6'd5, R_MAX, 16'd0, 16'd0, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0},
          1'b0, '0},
        '{'{REQ_TRIAL, 6'd5, 16'd0, 16'd0, 16'd0, 16'd0, 32'h12345678, 32'd0, 32'd0, 32'd0,
            1'b0, 1'b0}, 1'b0, '0}
    };

    function automatic void engine_clear();
        for (int i = 0; i < POP_SIZE_DEF; i++) begin
            adp_f[i]  = F_RESET;
            adp_cr[i] = CR_RESET;
            cnd_f[i]  = F_RESET;
            cnd_cr[i] = CR_RESET;
        end
        f_lo_r   = F_LOWER_RESET;
        f_span_r = F_UPPER_RESET;
        tau_r    = TAU_RESET;
        xmin_r   = longint'(X_MIN_RESET);
        xmax_r   = longint'(X_MAX_RESET);
    endfunction

    function automatic outcome_t engine_step(request_t rq);
        int       k;
        longint   d;
        longint   mut;
        logic [63:0] fw;
        outcome_t o;
        k = int'(rq.ind) % POP_SIZE_DEF;
        o = '0;
        case (rq.req)
            REQ_ADAPT: begin
                if (rq.rb < tau_r) begin
                    fw = 64'(f_lo_r) + ((64'(rq.ra) * 64'(f_span_r)) >> FRAC_W);
                    cnd_f[k] = (fw > 64'(F_SAT)) ? F_SAT : fw[F_W-1:0];
                end else begin
                    cnd_f[k] = adp_f[k];
                end
                cnd_cr[k] = (rq.rd < tau_r) ? rq.rc : adp_cr[k];
            end
            REQ_TRIAL: begin
                if (rq.ra < cnd_cr[k] || rq.forced) begin
                    d   = longint'($signed(rq.plus)) - longint'($signed(rq.minus));
                    mut = longint'($signed(rq.base)) + ((d * longint'(cnd_f[k])) >>> FRAC_W);
                    // below the lower bound wins when the bounds are crossed
                    if (mut < xmin_r)
                        mut = (xmin_r + longint'($signed(rq.target))) >>> 1;
                    else if (mut > xmax_r)
                        mut = (xmax_r + longint'($signed(rq.target))) >>> 1;
                    o.gene = mut[X_W-1:0];
                end else begin
                    o.gene = rq.target;
                end
            end
            REQ_SELECT: begin
                if ($signed(rq.base) <= $signed(rq.target)) begin
                    adp_f[k]  = cnd_f[k];
                    adp_cr[k] = cnd_cr[k];
                    o.acc     = 1'b1;
                end
            end
            default: ;
        endcase
        o.f  = cnd_f[k];
        o.cr = cnd_cr[k];
        return o;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
    endtask

    // result check, then register writes and accepted beats into the shadow
    always @(posedge i_clk) begin
        outcome_t exp_o;
        outcome_t pred;
        request_t rq;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (pending_results.size() == 0) begin
                    report("result with nothing pending", 64'(o_trial_gene), 64'd0);
                end else begin
                    exp_o = pending_results.pop_front();
                    if (o_trial_f !== exp_o.f)     report("trial_f", 64'(o_trial_f), 64'(exp_o.f));
                    if (o_trial_cr !== exp_o.cr)   report("trial_cr", 64'(o_trial_cr), 64'(exp_o.cr));
                    if (o_trial_gene !== exp_o.gene)
                        report("trial_gene", 64'(o_trial_gene), 64'(exp_o.gene));
                    if (o_accepted !== exp_o.acc)  report("accepted", 64'(o_accepted), 64'(exp_o.acc));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_F_LOWER: f_lo_r   = i_cfg_wdata[F_W-1:0];
                    CFG_F_UPPER: f_span_r = i_cfg_wdata[F_W-1:0];
                    CFG_TAU:     tau_r    = i_cfg_wdata[RAND_W-1:0];
                    CFG_X_MIN:   xmin_r   = longint'($signed(i_cfg_wdata));
                    CFG_X_MAX:   xmax_r   = longint'($signed(i_cfg_wdata));
                    default: ;
                endcase
            end
            if (start && busy === 1'b0) begin
                rq = '{t_req'(i_req_type), i_individual, i_rand_a, i_rand_b, i_rand_c, i_rand_d,
                       i_target_gene, i_base_gene, i_diff_plus, i_diff_minus, i_forced_dim,
                       i_spare_zero};
                pred = engine_step(rq);
                pending_results.push_back(cur_typed ? cur_want : pred);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_valid === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL self_adaptive_de_trial_engine_unit");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge once busy has been seen low after a rising edge
    task automatic send(request_t rq, logic typed, outcome_t want);
        while (gap_pct != 0 && burst_left == 0 && $urandom_range(0, 99) < gap_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        if (burst_left != 0)
            burst_left--;
        else if ($urandom_range(0, 49) == 0)
            burst_left = $urandom_range(10, 30);
        i_req_type    = rq.req;
        i_individual  = rq.ind;
        i_rand_a      = rq.ra;
        i_rand_b      = rq.rb;
        i_rand_c      = rq.rc;
        i_rand_d      = rq.rd;
        i_target_gene = rq.target;
        i_base_gene   = rq.base;
        i_diff_plus   = rq.plus;
        i_diff_minus  = rq.minus;
        i_forced_dim  = rq.forced;
        i_spare_zero  = rq.spare;
        cur_typed     = typed;
        cur_want      = want;
        start         = 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        start = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
    endtask

    task automatic write_settings(logic [F_W-1:0] fl, logic [F_W-1:0] fu, logic [RAND_W-1:0] t,
                                  logic [X_W-1:0] xmn, logic [X_W-1:0] xmx);
        put_reg(CFG_F_LOWER, 32'(fl));
        put_reg(CFG_F_UPPER, 32'(fu));
        put_reg(CFG_TAU, 32'(t));
        put_reg(CFG_X_MIN, xmn);
        put_reg(CFG_X_MAX, xmx);
        i_cfg_we = 1'b0;
        draw_tau = t;
    endtask

    function automatic logic [X_W-1:0] pick_gene();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                // a few units around zero, keeps most mutants inside the bounds
                v = int'($urandom_range(0, 1048576));
                return X_W'(v - 524288);
            end
            5, 6, 7: return $urandom;
            8:       return $urandom_range(0, 1) ? G_MAX : G_MIN;
            default: return $urandom_range(0, 1) ? G_ONES : 32'd0;
        endcase
    endfunction

    function automatic logic [RAND_W-1:0] pick_draw();
        int v;
        case ($urandom_range(0, 3))
            0: return RAND_W'($urandom_range(0, int'(draw_tau)));
            1: begin
                v = int'(draw_tau) + int'($urandom_range(0, 2)) - 1;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
                return RAND_W'(v);
            end
            default: return RAND_W'($urandom);
        endcase
    endfunction

    function automatic request_t noise_req();
        request_t rq;
        rq.req    = t_req'($urandom_range(0, 3));
        rq.ind    = IND_W'($urandom);
        rq.ra     = RAND_W'($urandom);
        rq.rb     = RAND_W'($urandom);
        rq.rc     = RAND_W'($urandom);
        rq.rd     = RAND_W'($urandom);
        rq.target = $urandom;
        rq.base   = $urandom;
        rq.plus   = $urandom;
        rq.minus  = $urandom;
        rq.forced = 1'($urandom);
        rq.spare  = 1'($urandom);
        return rq;
    endfunction

    // mostly whole generations for one individual: adapt, a few trial genes, select
    task automatic run_random(int n_items);
        int               done;
        int               dims;
        int               fdim;
        logic [IND_W-1:0] who;
        request_t         rq;
        done = 0;
        while (done < n_items) begin
            if ($urandom_range(0, 99) < 85) begin
                who = IND_W'($urandom);
                dims = $urandom_range(1, 6);
                fdim = $urandom_range(0, dims - 1);
                rq = noise_req();
                rq.req   = REQ_ADAPT;
                rq.ind   = who;
                rq.rb    = pick_draw();
                rq.rd    = pick_draw();
                rq.spare = ($urandom_range(0, 15) == 0);
                send(rq, 1'b0, '0);
                for (int d = 0; d < dims; d++) begin
                    rq = noise_req();
                    rq.req    = REQ_TRIAL;
                    rq.ind    = who;
                    rq.target = pick_gene();
                    rq.base   = pick_gene();
                    rq.plus   = pick_gene();
                    rq.minus  = pick_gene();
                    rq.forced = (d == fdim);
                    rq.spare  = ($urandom_range(0, 15) == 0);
                    send(rq, 1'b0, '0);
                end
                rq = noise_req();
                rq.req = REQ_SELECT;
                rq.ind = who;
                case ($urandom_range(0, 3))
                    0: rq.base = rq.target;
                    1: rq.base = rq.target - 32'd1;
                    2: rq.base = rq.target + 32'd1;
                    default: ;
                endcase
                rq.spare = ($urandom_range(0, 15) == 0);
                send(rq, 1'b0, '0);
                done += dims + 2;
            end else begin
                send(noise_req(), 1'b0, '0);
                done++;
            end
            if ($urandom_range(0, 99) == 0)
                wait_drain();
        end
    endtask

    initial begin
        engine_clear();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        start         = 1'b0;
        i_req_type    = REQ_NOP;
        i_individual  = '0;
        i_rand_a      = '0;
        i_rand_b      = '0;
        i_rand_c      = '0;
        i_rand_d      = '0;
        i_target_gene = '0;
        i_base_gene   = '0;
        i_diff_plus   = '0;
        i_diff_minus  = '0;
        i_forced_dim  = 1'b0;
        i_spare_zero  = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        gap_pct = 17;
        for (int r = 0; r < DIR_ROWS; r++)
            send(dir_rows[r].rq, dir_rows[r].typed, dir_rows[r].want);

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                wait_drain();
                case (p)
                    1: write_settings(F_W'($urandom_range(0, 65536)),
                                      F_W'($urandom_range(0, 65536)),
                                      RAND_W'($urandom_range(0, 65535)),
                                      -X_W'($urandom_range(65536, 16777216)),
                                      X_W'($urandom_range(65536, 16777216)));
                    2: write_settings(17'd65536, 17'd65536, 16'd65535, G_MIN, G_MAX);
                    3: write_settings(17'd0, 17'd0, 16'd0, 32'd0, 32'd0);
                    // crossed bounds: every mutant lands on a midpoint
                    4: write_settings(F_W'($urandom_range(0, 65536)),
                                      F_W'($urandom_range(0, 65536)), 16'd32768,
                                      32'd3276800, -32'sd3276800);
                    default: write_settings(F_LOWER_RESET, F_UPPER_RESET, TAU_RESET,
                                            X_MIN_RESET, X_MAX_RESET);
                endcase
            end
            gap_pct = (p < 2) ? 17 : (p < 4) ? 52 : 0;
            run_random(PHASE_ITEMS);
        end

        start = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0)
            report("results never delivered", 64'(pending_results.size()), 64'd0);
        if (err_count == 0)
            $display("PASS self_adaptive_de_trial_engine_unit");
        else
            $display("FAIL self_adaptive_de_trial_engine_unit");
        $finish;
    end

endmodule
